[rtl/core/smeu_pkg.sv]
package smeu_pkg;

  // Decoded operation of one request.
  typedef enum logic [4:0] {
    OP_PUSH    = 5'd0,
    OP_POP     = 5'd1,
    OP_ADD     = 5'd2,
    OP_SUB     = 5'd3,
    OP_MUL     = 5'd4,
    OP_DIV     = 5'd5,
    OP_HLT     = 5'd6,
    OP_CALL    = 5'd7,
    OP_RET     = 5'd8,
    OP_JMP     = 5'd9,
    OP_JE      = 5'd10,
    OP_JL      = 5'd11,
    OP_JLE     = 5'd12,
    OP_JMT     = 5'd13,
    OP_JFL     = 5'd14,
    OP_IN      = 5'd15,
    OP_OUT     = 5'd16,
    OP_UNKNOWN = 5'd17
  } op_e;

  typedef enum logic [1:0] {
    MS_RUN  = 2'd0,
    MS_HALT = 2'd1,
    MS_ERR  = 2'd2
  } mstate_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_BAD_IP    = 4'd1,
    ERR_UNKNOWN   = 4'd2,
    ERR_PUSH_FULL = 4'd3,
    ERR_POP_EMPTY = 4'd4,
    ERR_FEW_OPS   = 4'd5,
    ERR_CALL_FULL = 4'd6,
    ERR_RET_EMPTY = 4'd7,
    ERR_DIV_ZERO  = 4'd8
  } err_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_RIDX,
    B_MADDR,
    B_FETCH,
    B_LOAD,
    B_EXEC,
    B_MULDIV,
    B_WR2
  } back_state_e;

  localparam logic [4:0]  ACTION_LAST = 5'd16;
  localparam logic [63:0] LEN_LONG    = 64'd9;
  localparam logic [63:0] LEN_REG     = 64'd2;
  localparam logic [63:0] LEN_SHORT   = 64'd1;

  // One classified request as it sits in the queue.
  typedef struct packed {
    op_e         op;
    logic        use_reg;
    logic        use_mem;
    logic [63:0] arg;
    logic [63:0] in_value;
  } entry_t;

  // Queue head as the back end sees it.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } fq_t;

  // Back end requests toward the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } bctl_t;

endpackage

[rtl/core/smeu_ram.sv]
module smeu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/smeu_front.sv]
module smeu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  logic [4:0]         action_i,
  input  logic               use_reg_i,
  input  logic               use_mem_i,
  input  logic [63:0]        argument_i,
  input  logic [63:0]        in_value_i,
  input  smeu_pkg::bctl_t    bctl_i,
  output smeu_pkg::fq_t      fq_o
);
  import smeu_pkg::*;

  entry_t     slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  entry_t     cls;
  logic       push, pop;

  // Classify the raw action code; codes past the last defined one are unknown.
  always_comb begin
    cls.op       = (action_i > ACTION_LAST) ? OP_UNKNOWN : op_e'(action_i);
    cls.use_reg  = use_reg_i;
    cls.use_mem  = use_mem_i;
    cls.arg      = argument_i;
    cls.in_value = in_value_i;
  end

  assign req_stall_o = (count_q == 2'd2) || bctl_i.clearing;
  assign push        = req_valid_i && !req_stall_o;
  assign pop         = bctl_i.pop && (count_q != 2'd0);

  assign fq_o.valid = (count_q != 2'd0);
  assign fq_o.entry = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cls;
    end
  end

endmodule

[rtl/core/smeu_muldiv.sv]
module smeu_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_div_i,
  input  logic [63:0] op_a_i,
  input  logic [63:0] op_b_i,
  output logic        done_o,
  output logic [63:0] lo_o,
  output logic [63:0] rem_o
);

  // Bit-serial unit: one multiplier or quotient bit per cycle.
  logic        busy_q, done_q, div_q;
  logic [6:0]  cnt_q;
  logic [63:0] a_q, lo_q, acc_q;
  logic [64:0] shifted, diff;

  assign shifted = {acc_q, lo_q[63]};
  assign diff    = shifted - {1'b0, a_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= is_div_i;
      if (is_div_i) begin
        a_q  <= op_b_i;
        lo_q <= op_a_i;
      end else begin
        a_q  <= op_a_i;
        lo_q <= op_b_i;
      end
      acc_q <= 64'd0;
    end else if (busy_q) begin
      if (div_q) begin
        if (!diff[64]) begin
          acc_q <= diff[63:0];
          lo_q  <= {lo_q[62:0], 1'b1};
        end else begin
          acc_q <= shifted[63:0];
          lo_q  <= {lo_q[62:0], 1'b0};
        end
      end else begin
        if (lo_q[0]) acc_q <= acc_q + a_q;
        a_q  <= {a_q[62:0], 1'b0};
        lo_q <= {1'b0, lo_q[63:1]};
      end
    end
  end

  assign done_o = done_q;
  assign lo_o   = div_q ? lo_q : acc_q;
  assign rem_o  = acc_q;

endmodule

[rtl/core/smeu_back.sv]
module smeu_back #(
  parameter int STACK_DEPTH = 256,
  parameter int MEM_WORDS   = 1024,
  parameter int REG_COUNT   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     code_size_i,
  input  smeu_pkg::fq_t   fq_i,
  output smeu_pkg::bctl_t bctl_o,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output logic [63:0]     next_ip_o,
  output logic [1:0]      run_status_o,
  output logic [3:0]      error_code_o,
  output logic            out_valid_o,
  output logic [63:0]     out_value_o
);
  import smeu_pkg::*;

  localparam int  SAW      = $clog2(STACK_DEPTH);
  localparam int  SPW      = $clog2(STACK_DEPTH + 1);
  localparam int  MAW      = $clog2(MEM_WORDS);
  localparam int  MRW      = MAW + 1;
  localparam int  RW       = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam bit  MEM_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);
  localparam logic [MRW-1:0] MEM_MOD = MRW'(MEM_WORDS);

  // Register number reduction of an 8-bit index by compare and subtract.
  function automatic logic [RW-1:0] reg_index(logic [7:0] v);
    logic [15:0] r;
    r = {8'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(REG_COUNT) << k)) r = r - (16'(REG_COUNT) << k);
    end
    return RW'(r);
  endfunction

  // Folds eight more address bits into a running remainder by the memory size.
  function automatic logic [MRW-1:0] mod_byte(logic [MRW-1:0] rem, logic [7:0] bits);
    logic [MRW-1:0] r;
    r = rem;
    for (int k = 7; k >= 0; k--) begin
      r = {r[MRW-2:0], bits[k]};
      if (r >= MEM_MOD) r = r - MEM_MOD;
    end
    return r;
  endfunction

  back_state_e state_q, state_d;
  entry_t      cur_q, cur_d;
  logic        wait_q, wait_d;
  logic [RW-1:0]  ridx_q, ridx_d;
  logic [MAW-1:0] maddr_q, maddr_d, clr_q, clr_d;
  logic [63:0] msh_q, msh_d;
  logic [MRW-1:0] mrem_q, mrem_d;
  logic [2:0]  mcnt_q, mcnt_d;
  logic [63:0] b_q, b_d, mw_q, mw_d, ret_q, ret_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;
  logic [SPW-1:0] sp_q, sp_d, rsp_q, rsp_d;
  logic [63:0] ip_q, ip_d;
  mstate_e     mst_q, mst_d;
  err_e        err_q, err_d, err_c;
  logic [63:0] regs_q [REG_COUNT];

  logic        reg_we;
  logic [RW-1:0] reg_widx;
  logic [63:0] reg_wdata;

  logic           ds_we, rs_we, mem_we;
  logic [SAW-1:0] ds_waddr, ds_raddr, rs_waddr, rs_raddr;
  logic [MAW-1:0] mem_waddr;
  logic [63:0]    ds_wdata, rs_wdata, mem_wdata, ds_rdata, rs_rdata, mem_rdata;

  logic        md_start, md_div, md_done;
  logic [63:0] md_a, md_b, md_lo, md_rem;

  logic        fin, ov_c;
  logic [63:0] oval_c, a_w, regv, raw_addr;
  logic        take;

  logic        res_valid_q;
  logic [63:0] res_ip_q, res_oval_q;
  mstate_e     res_st_q;
  err_e        res_err_q;
  logic        res_ov_q;

  smeu_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_dstack (
    .clk_i, .we_i(ds_we), .waddr_i(ds_waddr), .wdata_i(ds_wdata),
    .raddr_i(ds_raddr), .rdata_o(ds_rdata)
  );

  smeu_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_rstack (
    .clk_i, .we_i(rs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata)
  );

  smeu_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_dmem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(maddr_q), .rdata_o(mem_rdata)
  );

  smeu_muldiv u_muldiv (
    .clk_i, .rst_ni, .start_i(md_start), .is_div_i(md_div),
    .op_a_i(md_a), .op_b_i(md_b), .done_o(md_done), .lo_o(md_lo), .rem_o(md_rem)
  );

  assign a_w      = ds_rdata;
  assign regv     = regs_q[ridx_q];
  assign raw_addr = cur_q.use_reg ? regv : cur_q.arg;
  assign rs_raddr = SAW'(rsp_q - SP_ONE);
  assign ds_raddr = (state_q == B_FETCH) ? SAW'(sp_q - SP_ONE) : SAW'(sp_q - SP_TWO);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    wait_d    = wait_q;
    ridx_d    = ridx_q;
    maddr_d   = maddr_q;
    clr_d     = clr_q;
    msh_d     = msh_q;
    mrem_d    = mrem_q;
    mcnt_d    = mcnt_q;
    b_d       = b_q;
    mw_d      = mw_q;
    ret_d     = ret_q;
    qneg_d    = qneg_q;
    rneg_d    = rneg_q;
    sp_d      = sp_q;
    rsp_d     = rsp_q;
    ip_d      = ip_q;
    mst_d     = mst_q;
    err_d     = err_q;
    err_c     = ERR_NONE;
    reg_we    = 1'b0;
    reg_widx  = ridx_q;
    reg_wdata = 64'd0;
    ds_we     = 1'b0;
    ds_waddr  = SAW'(sp_q);
    ds_wdata  = 64'd0;
    rs_we     = 1'b0;
    rs_waddr  = SAW'(rsp_q);
    rs_wdata  = ip_q + LEN_LONG;
    mem_we    = 1'b0;
    mem_waddr = maddr_q;
    mem_wdata = b_q;
    md_start  = 1'b0;
    md_div    = 1'b1;
    md_a      = 64'd0;
    md_b      = 64'd0;
    fin       = 1'b0;
    ov_c      = 1'b0;
    oval_c    = 64'd0;
    take      = 1'b0;
    bctl_o.pop      = 1'b0;
    bctl_o.clearing = (state_q == B_CLEAR);

    unique case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 64'd0;
        clr_d     = clr_q + MAW'(1);
        if (clr_q == MAW'(MEM_WORDS - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (fq_i.valid && !res_valid_q) begin
          bctl_o.pop = 1'b1;
          cur_d      = fq_i.entry;
          wait_d     = 1'b0;
          state_d    = B_RIDX;
        end
      end
      B_RIDX: begin
        ridx_d  = reg_index(cur_q.arg[7:0]);
        state_d = B_MADDR;
      end
      B_MADDR: begin
        if (MEM_POW2 || !cur_q.use_mem) begin
          maddr_d = raw_addr[MAW-1:0];
          state_d = B_FETCH;
        end else if (!wait_q) begin
          msh_d  = raw_addr;
          mrem_d = '0;
          mcnt_d = 3'd0;
          wait_d = 1'b1;
        end else begin
          mrem_d = mod_byte(mrem_q, msh_q[63:56]);
          msh_d  = {msh_q[55:0], 8'd0};
          mcnt_d = mcnt_q + 3'd1;
          if (mcnt_q == 3'd7) begin
            maddr_d = MAW'(mrem_d);
            wait_d  = 1'b0;
            state_d = B_FETCH;
          end
        end
      end
      B_FETCH: begin
        state_d = B_LOAD;
      end
      B_LOAD: begin
        b_d     = ds_rdata;
        mw_d    = mem_rdata;
        ret_d   = rs_rdata;
        state_d = B_EXEC;
      end
      B_EXEC: begin
        state_d = B_IDLE;
        fin     = 1'b1;
        if (mst_q != MS_RUN) begin
          fin = 1'b1;
        end else if (ip_q >= {32'd0, code_size_i}) begin
          err_c = ERR_BAD_IP;
        end else begin
          unique case (cur_q.op)
            OP_PUSH: begin
              if (sp_q == SP_FULL) err_c = ERR_PUSH_FULL;
              else begin
                ds_we    = 1'b1;
                ds_waddr = SAW'(sp_q);
                ds_wdata = cur_q.use_mem ? mw_q : (cur_q.use_reg ? regv : cur_q.arg);
                sp_d     = sp_q + SP_ONE;
                ip_d     = ip_q + (cur_q.use_reg ? LEN_REG : LEN_LONG);
              end
            end
            OP_POP: begin
              if (sp_q == '0) err_c = ERR_POP_EMPTY;
              else begin
                sp_d = sp_q - SP_ONE;
                if (cur_q.use_mem) mem_we = 1'b1;
                else if (cur_q.use_reg) begin
                  reg_we    = 1'b1;
                  reg_wdata = b_q;
                end
                ip_d = ip_q + (cur_q.use_reg ? LEN_REG :
                               (cur_q.use_mem ? LEN_LONG : LEN_SHORT));
              end
            end
            OP_ADD, OP_SUB: begin
              if (sp_q < SP_TWO) err_c = ERR_FEW_OPS;
              else begin
                ds_we    = 1'b1;
                ds_waddr = SAW'(sp_q - SP_TWO);
                ds_wdata = (cur_q.op == OP_ADD) ? a_w + b_q : a_w - b_q;
                sp_d     = sp_q - SP_ONE;
                ip_d     = ip_q + LEN_SHORT;
              end
            end
            OP_MUL: begin
              if (sp_q < SP_TWO) err_c = ERR_FEW_OPS;
              else begin
                fin      = 1'b0;
                md_start = 1'b1;
                md_div   = 1'b0;
                md_a     = a_w;
                md_b     = b_q;
                state_d  = B_MULDIV;
              end
            end
            OP_DIV: begin
              if (sp_q < SP_TWO) err_c = ERR_FEW_OPS;
              else if (b_q == 64'd0) err_c = ERR_DIV_ZERO;
              else begin
                fin      = 1'b0;
                md_start = 1'b1;
                md_a     = a_w[63] ? 64'd0 - a_w : a_w;
                md_b     = b_q[63] ? 64'd0 - b_q : b_q;
                qneg_d   = a_w[63] ^ b_q[63];
                rneg_d   = a_w[63];
                state_d  = B_MULDIV;
              end
            end
            OP_HLT: mst_d = MS_HALT;
            OP_CALL: begin
              if (rsp_q == SP_FULL) err_c = ERR_CALL_FULL;
              else begin
                rs_we = 1'b1;
                rsp_d = rsp_q + SP_ONE;
                ip_d  = cur_q.arg;
              end
            end
            OP_RET: begin
              if (rsp_q == '0) err_c = ERR_RET_EMPTY;
              else begin
                rsp_d = rsp_q - SP_ONE;
                ip_d  = ret_q;
              end
            end
            OP_JMP: ip_d = cur_q.arg;
            OP_JE, OP_JL, OP_JLE: begin
              if (sp_q < SP_TWO) err_c = ERR_FEW_OPS;
              else begin
                priority case (cur_q.op)
                  OP_JE:   take = (a_w == b_q);
                  OP_JL:   take = ($signed(a_w) < $signed(b_q));
                  default: take = ($signed(a_w) <= $signed(b_q));
                endcase
                ip_d = take ? cur_q.arg : ip_q + LEN_LONG;
                sp_d = sp_q - SP_TWO;
              end
            end
            OP_JMT: ip_d = (rsp_q == '0) ? cur_q.arg : ip_q + LEN_LONG;
            OP_JFL: ip_d = (rsp_q == SP_FULL) ? cur_q.arg : ip_q + LEN_LONG;
            OP_IN: begin
              reg_we    = 1'b1;
              reg_widx  = '0;
              reg_wdata = cur_q.in_value;
              ip_d      = ip_q + LEN_SHORT;
            end
            OP_OUT: begin
              ov_c   = 1'b1;
              oval_c = regs_q[0];
              ip_d   = ip_q + LEN_SHORT;
            end
            OP_UNKNOWN: err_c = ERR_UNKNOWN;
            default:    err_c = ERR_UNKNOWN;
          endcase
        end
        if (err_c != ERR_NONE) begin
          mst_d = MS_ERR;
          err_d = err_c;
        end
      end
      B_MULDIV: begin
        if (md_done) begin
          ds_we    = 1'b1;
          ds_waddr = SAW'(sp_q - SP_TWO);
          if (cur_q.op == OP_MUL) begin
            ds_wdata = md_lo;
            sp_d     = sp_q - SP_ONE;
            ip_d     = ip_q + LEN_SHORT;
            fin      = 1'b1;
            state_d  = B_IDLE;
          end else begin
            ds_wdata = rneg_q ? 64'd0 - md_rem : md_rem;
            state_d  = B_WR2;
          end
        end
      end
      B_WR2: begin
        ds_we    = 1'b1;
        ds_waddr = SAW'(sp_q - SP_ONE);
        ds_wdata = qneg_q ? 64'd0 - md_lo : md_lo;
        ip_d     = ip_q + LEN_SHORT;
        fin      = 1'b1;
        state_d  = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      wait_q      <= 1'b0;
      clr_q       <= '0;
      sp_q        <= '0;
      rsp_q       <= '0;
      ip_q        <= 64'd0;
      mst_q       <= MS_RUN;
      err_q       <= ERR_NONE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= 64'd0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      rsp_q   <= rsp_d;
      mst_q   <= mst_d;
      err_q   <= err_d;
      if (err_c == ERR_NONE) ip_q <= ip_d;
      if (reg_we) regs_q[reg_widx] <= reg_wdata;
      if (fin) res_valid_q <= 1'b1;
      else if (!res_stall_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ridx_q  <= ridx_d;
    maddr_q <= maddr_d;
    msh_q   <= msh_d;
    mrem_q  <= mrem_d;
    mcnt_q  <= mcnt_d;
    b_q     <= b_d;
    mw_q    <= mw_d;
    ret_q   <= ret_d;
    qneg_q  <= qneg_d;
    rneg_q  <= rneg_d;
    if (fin) begin
      res_ip_q   <= (err_c == ERR_NONE) ? ip_d : ip_q;
      res_st_q   <= mst_d;
      res_err_q  <= err_d;
      res_ov_q   <= ov_c;
      res_oval_q <= oval_c;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign next_ip_o    = res_ip_q;
  assign run_status_o = res_st_q;
  assign error_code_o = res_err_q;
  assign out_valid_o  = res_ov_q;
  assign out_value_o  = res_oval_q;

endmodule

[rtl/core/stack_machine_execute_unit_core.sv]
// Stack machine execute unit.
//
// Requests arrive on the req channel (req_valid_i / req_stall_o), one decoded
// instruction each, and every request yields exactly one result on the res
// channel (res_valid_o / res_stall_i), in order. The user must write the
// program size register (cfg_we_i / cfg_wdata_i) only while the unit is idle;
// the block itself does not enforce this.
//
// The front end classifies each request and holds up to two of them in a
// queue, so new requests are taken while a result waits at the output. The
// back end runs one instruction at a time through the register index, memory
// address, stack fetch, load and execute states of a sequencer. The next
// instruction leaves the queue in the cycle after the previous result is
// taken. Multiply and divide run in the shared bit-serial unit, and divide
// writes its quotient in a further state. With a memory size that is not a
// power of two, a memory address is reduced one byte at a time.
//
// After reset the data memory is zeroed word by word; requests are stalled
// until that pass ends. When the receiver stalls, the result holds and the back
// end waits, while the queue keeps accepting until it is full.
module stack_machine_execute_unit_core #(
  parameter int STACK_DEPTH = 256,
  parameter int MEM_WORDS   = 1024,
  parameter int REG_COUNT   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  logic [4:0]         action_i,
  input  logic               use_reg_i,
  input  logic               use_mem_i,
  input  logic [63:0]        argument_i,
  input  logic signed [63:0] in_value_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic [63:0]        next_ip_o,
  output logic [1:0]         run_status_o,
  output logic [3:0]         error_code_o,
  output logic               out_valid_o,
  output logic signed [63:0] out_value_o
);
  import smeu_pkg::*;

  // Program size in bytes; an instruction pointer at or past it faults.
  logic [31:0] code_size_q;
  fq_t         fq;
  bctl_t       bctl;
  logic [63:0] out_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_size_q <= 32'd0;
    end else if (cfg_we_i) begin
      code_size_q <= cfg_wdata_i;
    end
  end

  smeu_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .action_i, .use_reg_i, .use_mem_i,
    .argument_i, .in_value_i(64'(in_value_i)), .bctl_i(bctl), .fq_o(fq)
  );

  smeu_back #(
    .STACK_DEPTH(STACK_DEPTH), .MEM_WORDS(MEM_WORDS), .REG_COUNT(REG_COUNT)
  ) u_back (
    .clk_i, .rst_ni, .code_size_i(code_size_q), .fq_i(fq), .bctl_o(bctl),
    .res_valid_o, .res_stall_i, .next_ip_o, .run_status_o, .error_code_o,
    .out_valid_o, .out_value_o(out_value)
  );

  assign out_value_o = $signed(out_value);

endmodule

[rtl/core/smeu_checker.sv]
module smeu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_stall_i,
  input logic [63:0] next_ip_o,
  input logic [1:0]  run_status_o,
  input logic [3:0]  error_code_o,
  input logic        out_valid_o
);
  import smeu_pkg::*;

  // A running machine has never latched an error.
  a_run_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (run_status_o == MS_RUN) |-> error_code_o == ERR_NONE)
    else $error("running result carries an error code");

  // An error state always names its cause.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (run_status_o == MS_ERR) |-> error_code_o != ERR_NONE)
    else $error("error state without a code");

  // Output data only comes from an instruction that ran.
  a_out_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> run_status_o == MS_RUN)
    else $error("out value reported on a stopped machine");

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(next_ip_o))
    else $error("stalled result changed");

endmodule

bind stack_machine_execute_unit_core smeu_checker u_smeu_checker (.*);
